FILE: hw/rtl/cpf_pkg.sv
// ============================================================================
// cpf_pkg
// Shared types and constants for the command packet framer.
// ============================================================================
package cpf_pkg;

  localparam logic [7:0] SOP_BYTE    = 8'hFF;
  localparam logic [7:0] INVERT_MASK = 8'hFF;

  localparam logic       CMD_HEADER = 1'b0;
  localparam logic       CMD_DATA   = 1'b1;

  // Op queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Byte positions inside one op
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_SOP0  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SOP1  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DEV   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_CMD   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SEQ   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LEN   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_HCSUM = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DATA  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_DCSUM = 3'd1;

  // One classified op: a header (6 or 7 bytes) or a payload word (1 or 2 bytes)
  typedef struct packed {
    logic       is_hdr;
    logic       close;   // emit checksum byte after this op
    logic [7:0] b0;      // device id, or payload byte
    logic [7:0] b1;      // command id
    logic [7:0] b2;      // sequence number
    logic [7:0] b3;      // length byte
    logic [7:0] csum;    // inverted checksum
  } op_t;

  // Front to queue write side
  typedef struct packed {
    logic push;
    op_t  op;
  } qwr_t;

  // Queue to back read side
  typedef struct packed {
    logic nonempty;
    op_t  op;
  } qrd_t;

endpackage

FILE: hw/rtl/cpf_ifs.sv
// ============================================================================
// cpf channel interfaces
// Valid/ready channels for input words and framed output bytes.
// ============================================================================
interface cpf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] device_id;
  logic [7:0] command_id;
  logic [7:0] payload_length;
  logic [7:0] payload_byte;

  modport source (output valid, cmd, device_id, command_id, payload_length,
                  payload_byte, input ready);
  modport sink   (input valid, cmd, device_id, command_id, payload_length,
                  payload_byte, output ready);
endinterface

interface cpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_packet;

  modport source (output valid, out_byte, end_of_packet, input ready);
  modport sink   (input valid, out_byte, end_of_packet, output ready);
endinterface

FILE: hw/rtl/cpf_front.sv
// ============================================================================
// cpf_front
// Accepts input words, tracks packet state and pushes classified ops.
// ============================================================================
module cpf_front (
  input  logic        clk,
  input  logic        rst,
  cpf_in_if.sink      in_ch,
  input  logic        q_full,
  output cpf_pkg::qwr_t qwr
);
  import cpf_pkg::*;

  logic [7:0] sequence_number, sequence_number_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] bytes_remaining, bytes_remaining_next;
  logic       in_packet, in_packet_next;

  logic       accept;
  logic [7:0] lenb;
  logic [7:0] sum;
  logic [7:0] rem;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    sequence_number_next = sequence_number;
    running_sum_next     = running_sum;
    bytes_remaining_next = bytes_remaining;
    in_packet_next       = in_packet;
    lenb = in_ch.payload_length + 8'd1;
    sum  = 8'd0;
    rem  = 8'd0;
    qwr  = '0;
    if (accept) begin
      if (in_ch.cmd == CMD_HEADER) begin
        // an open packet is simply abandoned
        sum           = in_ch.device_id + in_ch.command_id + sequence_number + lenb;
        qwr.push      = 1'b1;
        qwr.op.is_hdr = 1'b1;
        qwr.op.close  = (in_ch.payload_length == 8'd0);
        qwr.op.b0     = in_ch.device_id;
        qwr.op.b1     = in_ch.command_id;
        qwr.op.b2     = sequence_number;
        qwr.op.b3     = lenb;
        qwr.op.csum   = sum ^ INVERT_MASK;
        running_sum_next = sum;
        if (in_ch.payload_length == 8'd0) begin
          sequence_number_next = sequence_number + 8'd1;
          bytes_remaining_next = 8'd0;
          in_packet_next       = 1'b0;
        end else begin
          bytes_remaining_next = in_ch.payload_length;
          in_packet_next       = 1'b1;
        end
      end else if (in_packet) begin
        sum           = running_sum + in_ch.payload_byte;
        rem           = bytes_remaining - 8'd1;
        qwr.push      = 1'b1;
        qwr.op.is_hdr = 1'b0;
        qwr.op.close  = (rem == 8'd0);
        qwr.op.b0     = in_ch.payload_byte;
        qwr.op.csum   = sum ^ INVERT_MASK;
        running_sum_next     = sum;
        bytes_remaining_next = rem;
        if (rem == 8'd0) begin
          sequence_number_next = sequence_number + 8'd1;
          in_packet_next       = 1'b0;
        end
      end
      // payload word outside a packet: dropped
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number <= 8'd0;
      running_sum     <= 8'd0;
      bytes_remaining <= 8'd0;
      in_packet       <= 1'b0;
    end else begin
      sequence_number <= sequence_number_next;
      running_sum     <= running_sum_next;
      bytes_remaining <= bytes_remaining_next;
      in_packet       <= in_packet_next;
    end
  end

endmodule

FILE: hw/rtl/cpf_queue.sv
// ============================================================================
// cpf_queue
// Short FIFO of ops between the front and the back.
// ============================================================================
module cpf_queue (
  input  logic          clk,
  input  logic          rst,
  input  cpf_pkg::qwr_t qwr,
  output logic          full,
  input  logic          pop,
  output cpf_pkg::qrd_t qrd
);
  import cpf_pkg::*;

  op_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full         = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qrd.nonempty = (count != '0);
  assign qrd.op       = mem[rd_ptr];
  assign do_push      = qwr.push && !full;
  assign do_pop       = pop && qrd.nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= qwr.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/cpf_back.sv
// ============================================================================
// cpf_back
// Unrolls each op into framed bytes, one byte per cycle while out_ch is ready.
// ============================================================================
module cpf_back (
  input  logic          clk,
  input  logic          rst,
  input  cpf_pkg::qrd_t qrd,
  output logic          pop,
  cpf_out_if.source     out_ch
);
  import cpf_pkg::*;

  op_t               cur;
  logic              cur_valid;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] last_step;
  logic              fire;
  logic              at_last;

  always_comb begin
    if (cur.is_hdr) begin
      last_step = cur.close ? STEP_HCSUM : STEP_LEN;
    end else begin
      last_step = cur.close ? STEP_DCSUM : STEP_DATA;
    end
  end

  assign fire    = out_ch.valid && out_ch.ready;
  assign at_last = (step == last_step);
  assign pop     = qrd.nonempty && (!cur_valid || (fire && at_last));

  assign out_ch.valid = cur_valid;

  always_comb begin
    out_ch.out_byte      = cur.b0;
    out_ch.end_of_packet = 1'b0;
    if (cur.is_hdr) begin
      case (step)
        STEP_SOP0:  out_ch.out_byte = SOP_BYTE;
        STEP_SOP1:  out_ch.out_byte = SOP_BYTE;
        STEP_DEV:   out_ch.out_byte = cur.b0;
        STEP_CMD:   out_ch.out_byte = cur.b1;
        STEP_SEQ:   out_ch.out_byte = cur.b2;
        STEP_LEN:   out_ch.out_byte = cur.b3;
        STEP_HCSUM: begin
          out_ch.out_byte      = cur.csum;
          out_ch.end_of_packet = 1'b1;
        end
        default:    out_ch.out_byte = cur.b0;
      endcase
    end else if (step == STEP_DCSUM) begin
      out_ch.out_byte      = cur.csum;
      out_ch.end_of_packet = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= qrd.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      step      <= '0;
    end else if (fire) begin
      if (at_last) begin
        cur_valid <= 1'b0;
        step      <= '0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/command_packet_framer_unit.sv
// ============================================================================
// command_packet_framer_unit
// Frames header and payload words into command packets, one byte per cycle while out_ch is ready.
// ============================================================================
//
//  channel  dir  handshake     word
//  -------  ---  ------------  -------------------------------------------
//  in_ch    in   valid/ready   cmd, device_id, command_id, payload_length,
//                              payload_byte
//  out_ch   out  valid/ready   out_byte, end_of_packet
//
//  A payload word yields 1 byte (2 on the last, with the checksum). A
//  header yields 6 bytes (7 at length zero); the output port's one byte
//  per cycle sets the sustained rate. The op queue (4 entries) lets the
//  front keep taking words while the back drains. Synchronous reset
//  clears the sequence number, packet state and queue. in_ch.ready
//  drops only when the queue is full; out_ch stalls hold the current
//  byte steady.
//
module command_packet_framer_unit (
  input  logic      clk,
  input  logic      rst,
  cpf_in_if.sink    in_ch,
  cpf_out_if.source out_ch
);
  import cpf_pkg::*;

  qwr_t qwr;   // front -> queue
  qrd_t qrd;   // queue -> back
  logic q_full;
  logic pop;

  // Classification and packet state (sequence, running sum, count)
  cpf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .qwr    (qwr)
  );

  // Decoupling queue of ops
  cpf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .qwr  (qwr),
    .full (q_full),
    .pop  (pop),
    .qrd  (qrd)
  );

  // Byte sequencer: start bytes, fields, payload, checksum
  cpf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qrd    (qrd),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: tb/cpf_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// cpf_checker
// Watches both channels of the framer, keeps its own copy of the framing
// state, predicts the bytes of every accepted word and compares each accepted
// output byte with the oldest prediction.
// ============================================================================
module cpf_checker (
  input  logic clk,
  input  logic rst,
  cpf_in_if    in_ch,
  cpf_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import cpf_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [7:0] value;
    logic       eop;
  } framed_byte_t;

  framed_byte_t expected_bytes[$];

  logic [7:0] seq_num;
  logic [7:0] csum_acc;
  logic [7:0] data_left;
  logic       pkt_open;
  int         errors = 0;

  task automatic push_byte(input logic [7:0] value, input logic eop);
    framed_byte_t fb;
    fb.value = value;
    fb.eop   = eop;
    expected_bytes.push_back(fb);
  endtask

  task automatic close_frame();
    push_byte(csum_acc ^ INVERT_MASK, 1'b1);
    seq_num   = seq_num + 8'd1;
    pkt_open  = 1'b0;
    data_left = 8'd0;
  endtask

  task automatic frame_word(input logic c, input logic [7:0] dev, input logic [7:0] cid,
                            input logic [7:0] len, input logic [7:0] pb);
    logic [7:0] len_byte;
    len_byte = len + 8'd1;
    if (c == CMD_HEADER) begin
      // a header always starts fresh; any open packet is dropped silently
      push_byte(SOP_BYTE, 1'b0);
      push_byte(SOP_BYTE, 1'b0);
      push_byte(dev, 1'b0);
      push_byte(cid, 1'b0);
      push_byte(seq_num, 1'b0);
      push_byte(len_byte, 1'b0);
      csum_acc  = dev + cid + seq_num + len_byte;
      data_left = len;
      pkt_open  = 1'b1;
      if (len == 8'd0) close_frame();
    end else if (pkt_open) begin
      push_byte(pb, 1'b0);
      csum_acc  = csum_acc + pb;
      data_left = data_left - 8'd1;
      if (data_left == 8'd0) close_frame();
    end
  endtask

  task automatic check_byte(input logic [7:0] value, input logic eop);
    framed_byte_t want;
    if (expected_bytes.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: unexpected byte %02h eop %0b", $time, value, eop);
    end else begin
      want = expected_bytes.pop_front();
      if (want.value !== value || want.eop !== eop) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: byte mismatch: expected %02h eop %0b, got %02h eop %0b",
                   $time, want.value, want.eop, value, eop);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seq_num   = 8'd0;
      csum_acc  = 8'd0;
      data_left = 8'd0;
      pkt_open  = 1'b0;
      expected_bytes.delete();
    end else begin
      // predict first so a byte leaving on the same edge can find its entry
      if (in_ch.valid && in_ch.ready)
        frame_word(in_ch.cmd, in_ch.device_id, in_ch.command_id,
                   in_ch.payload_length, in_ch.payload_byte);
      if (out_ch.valid && out_ch.ready)
        check_byte(out_ch.out_byte, out_ch.end_of_packet);
    end
    fail_count <= errors;
    pending    <= expected_bytes.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Drives header and payload words into the command packet framer with random
// gaps and output stalls; the checker beside the block predicts and compares
// every framed byte, and this module gives the verdict.
// ============================================================================
module tb_top;
  import cpf_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_WORDS   = 150;
  localparam int CALM_WORDS     = 115;  // no idling after this many random words
  localparam int WRAP_PACKETS   = 8;    // short run of zero-length packets
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 500;

  logic clk;
  logic rst;

  cpf_in_if  in_ch ();
  cpf_out_if out_ch ();

  int fail_count;
  int pending;

  // idle control for both sides; calm is shared by them
  bit calm;
  int in_gap_pct;
  int out_gap_pct;
  int out_stall;
  int quiet_cycles;

  // words of the random part that the block does not drop
  int framed_words;
  // payload words still owed to the open packet, as the generator sees it
  int data_owed;

  command_packet_framer_unit DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  cpf_checker framer_check (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Input side. A word is held until the edge where valid and ready meet.
  // valid stays high between back-to-back words; it only drops for a gap.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic c, input logic [7:0] dev, input logic [7:0] cid,
                           input logic [7:0] len, input logic [7:0] pb);
    int gap;
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= c;
    in_ch.device_id      <= dev;
    in_ch.command_id     <= cid;
    in_ch.payload_length <= len;
    in_ch.payload_byte   <= pb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // unused fields of each word get random values so their bits move too
  task automatic send_header(input logic [7:0] dev, input logic [7:0] cid,
                             input logic [7:0] len);
    send_word(CMD_HEADER, dev, cid, len, 8'($urandom));
  endtask

  task automatic send_data(input logic [7:0] pb);
    send_word(CMD_DATA, 8'($urandom), 8'($urandom), 8'($urandom), pb);
  endtask

  // --------------------------------------------------------------------------
  // Output side: stall bursts, with a stall rate that drifts so some
  // stretches run without any back-pressure.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0)
      out_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
    if (rst) begin
      out_stall = 0;
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < out_gap_pct) begin
      out_stall = $urandom_range(1, 4) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog: too long with no word moving on either side ends the run
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL command_packet_framer_unit");
        $finish;
      end
    end
  end

  initial begin
    int roll;
    int len;
    int sent;
    logic [7:0] len_b;

    rst                  = 1'b1;
    calm                 = 1'b0;
    in_gap_pct           = 25;
    out_gap_pct          = 25;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_HEADER;
    in_ch.device_id      = 8'h00;
    in_ch.command_id     = 8'h00;
    in_ch.payload_length = 8'h00;
    in_ch.payload_byte   = 8'h00;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // zero-length packet: checksum straight after the header
    send_header(8'h00, 8'h00, 8'd0);
    // all-ones ids and a single all-ones payload byte
    send_header(8'hFF, 8'hFF, 8'd1);
    send_data(8'hFF);
    // payload word with no packet open is dropped
    send_data(8'h3C);
    send_header(8'h5A, 8'hA5, 8'd2);
    send_data(8'h00);
    send_data(8'h80);
    // header mid-packet abandons the open one; seq must not advance
    send_header(8'h12, 8'h34, 8'd3);
    send_data(8'h01);
    send_header(8'h56, 8'h78, 8'd0);
    // length 255: length byte wraps to 0; abandoned after two bytes
    send_header(8'hC3, 8'h3C, 8'd255);
    send_data(8'h7F);
    send_data(8'hFE);
    // length 248, abandoned after one byte, then a short packet closes cleanly
    send_header(8'h0F, 8'hF0, 8'd248);
    send_data(8'h55);
    send_header(8'hAA, 8'h55, 8'd1);
    send_data(8'hAA);
    // strays after a closed packet
    send_data(8'h00);
    send_data(8'hFF);

    // ---- a run of zero-length packets ----
    in_gap_pct = 10;
    for (int i = 0; i < WRAP_PACKETS; i++)
      send_header(8'($urandom), 8'($urandom), 8'd0);

    // ---- random part: mostly well-formed packets, some broken, some noise ----
    framed_words = 0;
    data_owed    = 0;
    while (framed_words < RANDOM_WORDS) begin
      if (framed_words >= CALM_WORDS) calm = 1'b1;
      in_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        // noise word: either feeds the open packet or gets dropped
        send_data(8'($urandom));
        if (data_owed > 0) begin
          data_owed--;
          framed_words++;
        end
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5)
          len = $urandom_range(40, 255);
        else if (roll < 30)
          len = 0;
        else
          len = $urandom_range(1, 8);
        len_b = 8'(len);
        send_header(8'($urandom), 8'($urandom), len_b);
        framed_words++;
        // big lengths and some short ones are cut off early on purpose
        if (len > 8 || $urandom_range(0, 99) < 12)
          sent = (len == 0) ? 0 : $urandom_range(0, (len > 6) ? 6 : len - 1);
        else
          sent = len;
        for (int k = 0; k < sent; k++)
          send_data(8'($urandom));
        framed_words += sent;
        data_owed = len - sent;
      end
    end

    // ---- drain ----
    in_ch.valid <= 1'b0;
    calm = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("PASS command_packet_framer_unit");
    else
      $display("FAIL command_packet_framer_unit");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cpf_pkg.sv
hw/rtl/cpf_ifs.sv
hw/rtl/cpf_front.sv
hw/rtl/cpf_queue.sv
hw/rtl/cpf_back.sv
hw/rtl/command_packet_framer_unit.sv
tb/cpf_checker.sv
tb/tb_top.sv
